FILE: rtl/core/bsds_pkg.sv
// Shared types and constants of the bus slave deadline scheduler.
// No dependencies; used by bus_slave_deadline_scheduler.
`timescale 1ns / 1ps
`default_nettype none
package bsds_pkg;

  localparam int unsigned NumSlaves = 8;
  localparam int unsigned SlaveW    = 3;
  localparam int unsigned CountW    = 4;
  localparam int unsigned TimeW     = 48;
  localparam int unsigned HzW       = 20;
  localparam int unsigned DurW      = 16;

  // one second in microseconds, dividend of the interval division
  localparam logic [HzW-1:0] UsPerS = 20'd1000000;

  // register map
  localparam logic [2:0] RegSlaveCountAddr = 3'd0;

  typedef enum logic [1:0] {
    ACT_PREPARE = 2'd0,
    ACT_START   = 2'd1,
    ACT_DONE    = 2'd2,
    ACT_FORCE   = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_START_WR,
    ST_DONE_RD,
    ST_DONE_ADD,
    ST_SCAN_BASE_RD,
    ST_SCAN_BASE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_FORCE_CHK,
    ST_FORCE_RD,
    ST_FORCE_EVAL,
    ST_RESULT
  } state_e;

  // time sum that sticks at the largest time value
  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/bus_slave_deadline_scheduler.sv
// Earliest-deadline polling scheduler over eight bus slaves.
// Prepare writes one memory row per cycle; start runs a serial 20-step interval divider;
// done stores the duration, extends a forced slave's deadline and scans with a read and a
// compare per slave; force checks, reads and evaluates. One word in flight at a time; the
// next word is taken in the cycle after the result is registered.
// Reset: deadlines and durations read as zero via row valid bits, marks clear,
// slave_count 1, scheduler unprepared; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module bus_slave_deadline_scheduler (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: now_us[47:0], interval_hz[67:48], duration_us[83:68], slave_index[86:84]
  input  wire logic [87:0] s_axis_tdata,
  // tuser: action[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: chosen_slave[2:0], chosen_deadline[50:3], wake_loop[51],
  //        request_ignored[52]
  output logic [55:0]      m_axis_tdata,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned N  = bsds_pkg::NumSlaves;
  localparam int unsigned SW = bsds_pkg::SlaveW;
  localparam int unsigned CW = bsds_pkg::CountW;
  localparam int unsigned TW = bsds_pkg::TimeW;
  localparam int unsigned HW = bsds_pkg::HzW;
  localparam int unsigned UW = bsds_pkg::DurW;

  bsds_pkg::state_e  state_q, state_d;
  bsds_pkg::action_e act_q;

  // latched input word
  logic [TW-1:0] now_q;
  logic [HW-1:0] hz_q;
  logic [UW-1:0] dur_q;
  logic [SW-1:0] idx_q;

  // scheduler state
  logic [CW-1:0] cnt_q, cnt_d;
  logic [N-1:0]  fmark_q, fmark_d;
  logic [N-1:0]  lmark_q, lmark_d;
  logic [SW-1:0] next_q, next_d;
  logic [SW-1:0] cur_q, cur_d;
  logic          active_q, active_d;
  logic          prepared_q, prepared_d;
  logic          ign_q, ign_d;
  logic [CW-1:0] ptr_q, ptr_d;

  // divider
  logic [HW-1:0] rem_q, rem_d;
  logic [HW-1:0] quo_q, quo_d;
  logic [4:0]    dbit_q, dbit_d;
  logic [HW:0]   rem_sh;
  logic [HW-1:0] hz_eff;

  // scan and result
  logic [TW-1:0] best_q, best_d;
  logic [SW-1:0] res_slave_q, res_slave_d;
  logic [TW-1:0] res_dl_q, res_dl_d;
  logic          res_wake_q, res_wake_d;
  logic          res_ign_q, res_ign_d;
  logic [55:0]   out_q, out_d;
  logic          ovalid_q, ovalid_d;

  // deadline and duration memories with row valid bits
  logic [TW-1:0] dmem [N];
  logic [UW-1:0] umem [N];
  logic [N-1:0]  dvalid_q, dvalid_d;
  logic [N-1:0]  uvalid_q, uvalid_d;
  logic          d_we, u_we;
  logic [SW-1:0] d_wa, u_wa, d_ra, u_ra;
  logic [TW-1:0] d_wd;
  logic [UW-1:0] u_wd;
  logic [TW-1:0] drd_q;
  logic [UW-1:0] urd_q;
  logic          drd_ok_q, urd_ok_q;
  logic [TW-1:0] drd;
  logic [UW-1:0] urd;

  logic [CW-1:0] cnt_eff;
  logic          accept;
  logic          cfg_wr;
  logic [TW-1:0] sum;
  logic [TW-1:0] ts;

  // configuration access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == bsds_pkg::RegSlaveCountAddr);
  assign prdata = (paddr == bsds_pkg::RegSlaveCountAddr) ? {28'd0, cnt_q} : 32'd0;

  always_comb begin
    cnt_d = cfg_wr ? pwdata[CW-1:0] : cnt_q;
  end

  // clamp count to 1..N
  always_comb begin
    if (cnt_q == '0) begin
      cnt_eff = CW'(1);
    end else if (cnt_q > CW'(N)) begin
      cnt_eff = CW'(N);
    end else begin
      cnt_eff = cnt_q;
    end
  end

  assign s_axis_tready = (state_q == bsds_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = out_q;

  assign drd    = drd_ok_q ? drd_q : '0;
  assign urd    = urd_ok_q ? urd_q : '0;
  assign hz_eff = (hz_q == '0) ? HW'(1) : hz_q;
  assign rem_sh = {rem_q, bsds_pkg::UsPerS[5'(HW-1) - dbit_q]};
  assign sum    = bsds_pkg::sat_add(now_q, {{(TW-HW){1'b0}}, quo_q});
  assign ts     = bsds_pkg::sat_add(now_q, {{(TW-UW-1){1'b0}}, urd, 1'b0});

  // next state and datapath control
  always_comb begin
    state_d     = state_q;
    fmark_d     = fmark_q;
    lmark_d     = lmark_q;
    next_d      = next_q;
    cur_d       = cur_q;
    active_d    = active_q;
    prepared_d  = prepared_q;
    ign_d       = ign_q;
    ptr_d       = ptr_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dbit_d      = dbit_q;
    best_d      = best_q;
    res_slave_d = res_slave_q;
    res_dl_d    = res_dl_q;
    res_wake_d  = res_wake_q;
    res_ign_d   = res_ign_q;
    out_d       = out_q;
    ovalid_d    = ovalid_q && !m_axis_tready;
    dvalid_d    = dvalid_q;
    uvalid_d    = uvalid_q;
    d_we        = 1'b0;
    d_wa        = next_q;
    d_wd        = now_q;
    u_we        = 1'b0;
    u_wa        = cur_q;
    u_wd        = dur_q;
    d_ra        = next_q;
    u_ra        = idx_q;

    case (state_q)
      bsds_pkg::ST_IDLE: begin
        if (accept) begin
          ptr_d      = '0;
          rem_d      = '0;
          quo_d      = '0;
          dbit_d     = '0;
          ign_d      = 1'b0;
          res_wake_d = 1'b0;
          res_ign_d  = 1'b0;
          case (bsds_pkg::action_e'(s_axis_tuser))
            bsds_pkg::ACT_PREPARE: state_d = bsds_pkg::ST_PREP;
            bsds_pkg::ACT_START:   state_d = bsds_pkg::ST_DIV;
            bsds_pkg::ACT_DONE:    state_d = bsds_pkg::ST_DONE_RD;
            default:               state_d = bsds_pkg::ST_FORCE_CHK;
          endcase
        end
      end

      // write one row per cycle
      bsds_pkg::ST_PREP: begin
        d_we = 1'b1;
        d_wa = ptr_q[SW-1:0];
        d_wd = now_q;
        u_we = 1'b1;
        u_wa = ptr_q[SW-1:0];
        u_wd = '0;
        dvalid_d[ptr_q[SW-1:0]] = 1'b1;
        uvalid_d[ptr_q[SW-1:0]] = 1'b1;
        ptr_d = ptr_q + CW'(1);
        if (ptr_q == CW'(N - 1)) begin
          fmark_d     = '0;
          lmark_d     = '0;
          next_d      = '0;
          active_d    = 1'b0;
          prepared_d  = 1'b1;
          res_slave_d = '0;
          res_dl_d    = now_q;
          state_d     = bsds_pkg::ST_RESULT;
        end
      end

      // restoring division, one quotient bit per cycle
      bsds_pkg::ST_DIV: begin
        if (rem_sh >= {1'b0, hz_eff}) begin
          rem_d = HW'(rem_sh - {1'b0, hz_eff});
          quo_d = {quo_q[HW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[HW-1:0];
          quo_d = {quo_q[HW-2:0], 1'b0};
        end
        dbit_d = dbit_q + 5'd1;
        if (dbit_q == 5'(HW - 1)) begin
          state_d = bsds_pkg::ST_START_WR;
        end
      end

      bsds_pkg::ST_START_WR: begin
        d_we                = 1'b1;
        d_wa                = next_q;
        d_wd                = sum;
        dvalid_d[next_q]    = 1'b1;
        cur_d               = next_q;
        fmark_d[next_q]     = 1'b0;
        lmark_d[next_q]     = 1'b0;
        active_d            = 1'b1;
        res_slave_d         = next_q;
        res_dl_d            = sum;
        state_d             = bsds_pkg::ST_RESULT;
      end

      // store duration, fetch current deadline
      bsds_pkg::ST_DONE_RD: begin
        active_d        = 1'b0;
        u_we            = 1'b1;
        u_wa            = cur_q;
        u_wd            = dur_q;
        uvalid_d[cur_q] = 1'b1;
        d_ra            = cur_q;
        state_d         = bsds_pkg::ST_DONE_ADD;
      end

      bsds_pkg::ST_DONE_ADD: begin
        if (fmark_q[cur_q]) begin
          d_we            = 1'b1;
          d_wa            = cur_q;
          d_wd            = bsds_pkg::sat_add(drd, {{(TW-UW){1'b0}}, dur_q});
          dvalid_d[cur_q] = 1'b1;
        end
        state_d = bsds_pkg::ST_SCAN_BASE_RD;
      end

      bsds_pkg::ST_SCAN_BASE_RD: begin
        d_ra    = next_q;
        state_d = bsds_pkg::ST_SCAN_BASE;
      end

      bsds_pkg::ST_SCAN_BASE: begin
        best_d  = drd;
        ptr_d   = '0;
        state_d = bsds_pkg::ST_SCAN_RD;
      end

      bsds_pkg::ST_SCAN_RD: begin
        d_ra    = ptr_q[SW-1:0];
        state_d = bsds_pkg::ST_SCAN_CMP;
      end

      // keep the strictly earliest deadline
      bsds_pkg::ST_SCAN_CMP: begin
        if (drd < best_q) begin
          best_d = drd;
          next_d = ptr_q[SW-1:0];
        end
        ptr_d = ptr_q + CW'(1);
        if (ptr_q + CW'(1) == cnt_eff) begin
          res_slave_d = next_d;
          res_dl_d    = best_d;
          state_d     = bsds_pkg::ST_RESULT;
        end else begin
          state_d = bsds_pkg::ST_SCAN_RD;
        end
      end

      bsds_pkg::ST_FORCE_CHK: begin
        if (!prepared_q || ({1'b0, idx_q} >= cnt_eff) || fmark_q[idx_q]) begin
          ign_d     = 1'b1;
          res_ign_d = 1'b1;
        end else begin
          fmark_d[idx_q]  = 1'b1;
          d_we            = 1'b1;
          d_wa            = idx_q;
          d_wd            = now_q;
          dvalid_d[idx_q] = 1'b1;
        end
        state_d = bsds_pkg::ST_FORCE_RD;
      end

      bsds_pkg::ST_FORCE_RD: begin
        d_ra    = next_q;
        u_ra    = idx_q;
        state_d = bsds_pkg::ST_FORCE_EVAL;
      end

      // preempt the chosen slave when no update runs
      bsds_pkg::ST_FORCE_EVAL: begin
        res_slave_d = next_q;
        res_dl_d    = drd;
        if (!ign_q && !active_q) begin
          res_wake_d = 1'b1;
          if (!lmark_q[next_q] && !fmark_q[next_q]) begin
            if (!(ts < drd)) begin
              lmark_d[next_q] = 1'b1;
            end
            next_d      = idx_q;
            res_slave_d = idx_q;
            res_dl_d    = now_q;
          end
        end
        state_d = bsds_pkg::ST_RESULT;
      end

      // hand the word to the output register
      bsds_pkg::ST_RESULT: begin
        if (!ovalid_q || m_axis_tready) begin
          out_d    = {3'd0, res_ign_q, res_wake_q, res_dl_q, res_slave_q};
          ovalid_d = 1'b1;
          state_d  = bsds_pkg::ST_IDLE;
        end
      end

      default: state_d = bsds_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= bsds_pkg::ST_IDLE;
      cnt_q      <= CW'(1);
      fmark_q    <= '0;
      lmark_q    <= '0;
      next_q     <= '0;
      cur_q      <= '0;
      active_q   <= 1'b0;
      prepared_q <= 1'b0;
      ovalid_q   <= 1'b0;
      dvalid_q   <= '0;
      uvalid_q   <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      fmark_q    <= fmark_d;
      lmark_q    <= lmark_d;
      next_q     <= next_d;
      cur_q      <= cur_d;
      active_q   <= active_d;
      prepared_q <= prepared_d;
      ovalid_q   <= ovalid_d;
      dvalid_q   <= dvalid_d;
      uvalid_q   <= uvalid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= bsds_pkg::action_e'(s_axis_tuser);
      now_q <= s_axis_tdata[47:0];
      hz_q  <= s_axis_tdata[67:48];
      dur_q <= s_axis_tdata[83:68];
      idx_q <= s_axis_tdata[86:84];
    end
    ign_q       <= ign_d;
    ptr_q       <= ptr_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    dbit_q      <= dbit_d;
    best_q      <= best_d;
    res_slave_q <= res_slave_d;
    res_dl_q    <= res_dl_d;
    res_wake_q  <= res_wake_d;
    res_ign_q   <= res_ign_d;
    out_q       <= out_d;
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (d_we) begin
      dmem[d_wa] <= d_wd;
    end
    if (u_we) begin
      umem[u_wa] <= u_wd;
    end
    drd_q    <= dmem[d_ra];
    urd_q    <= umem[u_ra];
    drd_ok_q <= dvalid_q[d_ra];
    urd_ok_q <= uvalid_q[u_ra];
  end

  // checks
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == bsds_pkg::ST_IDLE)
    else $error("input taken outside idle");

  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bsds_pkg::ST_DIV |-> dbit_q < 5'(HW))
    else $error("divider step out of range");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bsds_pkg::ST_RESULT |-> !(res_wake_q && res_ign_q))
    else $error("wake and ignore both set");

  a_prep_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bsds_pkg::ST_PREP && ptr_q == CW'(N - 1)) |=>
      (prepared_q && next_q == '0 && fmark_q == '0))
    else $error("prepare did not finish");

  a_start_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bsds_pkg::ST_START_WR |=> active_q && act_q == bsds_pkg::ACT_START)
    else $error("start did not mark the scheduler busy");

endmodule
`default_nettype wire
